### rtl/ungapped_overlap_cost_search_core_assert.svh
// ---------------------------------------------------------------------------
// ungapped overlap cost search core - assertion macros
// clocked assertions on i_clk, with or without the reset qualifier
// ---------------------------------------------------------------------------
`ifndef UNGAPPED_OVERLAP_COST_SEARCH_CORE_ASSERT_SVH
`define UNGAPPED_OVERLAP_COST_SEARCH_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only while out of reset
`define UOCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// checked at every edge, reset included
`define UOCS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define UOCS_ASSERT(label, prop, msg)
`define UOCS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### rtl/uocs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uocs_pkg
// shared types and constants of the overlap cost search core
// ---------------------------------------------------------------------------
package uocs_pkg;

    localparam int SYMBOL_BITS  = 5;
    localparam int SUM_BITS     = 16;
    localparam int INDEX_BITS   = 16;
    localparam int COST_ENTRIES = 1024;

    typedef logic [SYMBOL_BITS-1:0] t_symbol;
    typedef logic [SUM_BITS-1:0]    t_sum;
    typedef logic [INDEX_BITS-1:0]  t_index;

    localparam t_sum SUM_MAX = '1;

    typedef enum logic [1:0] {
        OP_COST_WRITE   = 2'd0,
        OP_QUERY_APPEND = 2'd1,
        OP_DATABASE     = 2'd2
    } t_op;

    // one slot of the candidate lane running towards cell 0
    typedef struct packed {
        logic   valid;
        t_sum   value;
        t_index index;
    } t_lane;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic    db_step;
        t_symbol db_sym;
        t_index  db_pos;
        logic    cost_we;
        t_symbol cost_row;
        t_symbol cost_col;
        logic    append;
        t_symbol append_sym;
        logic    load_we;
        t_symbol load_row;
        logic    load_done;
        logic    scan_inject;
        logic    clear;
    } t_cell_ctrl;

endpackage
`default_nettype wire

### rtl/uocs_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uocs_in_if
// input item channel: operation, symbol and cost table write fields
// ---------------------------------------------------------------------------
interface uocs_in_if import uocs_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    t_symbol    symbol;
    t_symbol    cost_row;
    t_symbol    cost_column;
    logic [7:0] cost_value;
    logic       final_symbol;

    modport source (
        output valid, operation, symbol, cost_row, cost_column, cost_value, final_symbol,
        input  ready
    );
    modport sink (
        input  valid, operation, symbol, cost_row, cost_column, cost_value, final_symbol,
        output ready
    );
endinterface
`default_nettype wire

### rtl/uocs_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uocs_out_if
// result item channel: best cost, end index and overlap case
// ---------------------------------------------------------------------------
interface uocs_out_if import uocs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_sum   best_cost;
    t_index end_index;
    logic   match_case;

    modport source (
        output valid, best_cost, end_index, match_case,
        input  ready
    );
    modport sink (
        input  valid, best_cost, end_index, match_case,
        output ready
    );
endinterface
`default_nettype wire

### rtl/uocs_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uocs_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module uocs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/uocs_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uocs_cell
// one query position: cost column, diagonal sum and one candidate lane slot
// ---------------------------------------------------------------------------
module uocs_cell import uocs_pkg::*; #(
    parameter int COST_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctrl           i_ctrl,
    input  wire logic [COST_BITS-1:0] i_cost_val,
    input  wire t_sum                 i_left_sum,
    input  wire logic                 i_left_active,
    input  wire logic                 i_right_active,
    input  wire t_lane                i_lane,
    input  wire t_index               i_index,
    output t_sum                      o_sum,
    output logic                      o_active,
    output t_lane                     o_lane
);

    localparam int ROWS = 1 << SYMBOL_BITS;

    logic [COST_BITS-1:0] r_col [ROWS];
    t_symbol              r_sym;
    logic                 r_active;
    logic                 r_loading;
    t_sum                 r_sum;
    logic                 r_lane_valid;
    t_sum                 r_lane_value;
    t_index               r_lane_index;

    logic                 w_free;
    logic                 w_last;
    logic [COST_BITS-1:0] w_cost;
    logic [SUM_BITS:0]    w_wide;
    t_sum                 w_new;
    t_lane                n_lane;

    assign w_free = i_left_active & ~r_active;
    assign w_last = r_active & ~i_right_active;
    assign w_cost = r_col[i_ctrl.db_sym];
    assign w_wide = {1'b0, i_left_sum} + (SUM_BITS+1)'(w_cost);
    assign w_new  = w_wide[SUM_BITS] ? SUM_MAX : w_wide[SUM_BITS-1:0];

    // the tail cell drops its fresh sum into the lane, a scan drops all sums
    always_comb begin
        priority if (i_ctrl.db_step && w_last) begin
            n_lane = '{valid: 1'b1, value: w_new, index: i_ctrl.db_pos};
        end else if (i_ctrl.scan_inject && r_active) begin
            n_lane = '{valid: 1'b1, value: r_sum, index: i_index};
        end else begin
            n_lane = i_lane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_loading    <= 1'b0;
            r_sum        <= '0;
            r_lane_valid <= 1'b0;
        end else begin
            if (i_ctrl.append && w_free) begin
                r_active  <= 1'b1;
                r_loading <= 1'b1;
            end else if (i_ctrl.load_done) begin
                r_loading <= 1'b0;
            end
            priority if (i_ctrl.clear) begin
                r_sum <= '0;
            end else if (i_ctrl.db_step && r_active) begin
                r_sum <= w_new;
            end
            r_lane_valid <= n_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.append && w_free) begin
            r_sym <= i_ctrl.append_sym;
        end
        if (i_ctrl.load_we && r_loading) begin
            r_col[i_ctrl.load_row] <= i_cost_val;
        end else if (i_ctrl.cost_we && r_active && (r_sym == i_ctrl.cost_col)) begin
            r_col[i_ctrl.cost_row] <= i_cost_val;
        end
        r_lane_value <= n_lane.value;
        r_lane_index <= n_lane.index;
    end

    assign o_sum    = r_sum;
    assign o_active = r_active;
    assign o_lane   = '{valid: r_lane_valid, value: r_lane_value, index: r_lane_index};

endmodule
`default_nettype wire

### rtl/ungapped_overlap_cost_search_core.sv
// ---------------------------------------------------------------------------
// ungapped_overlap_cost_search_core
// prefix/suffix overlap search with mismatch costs over a row of query cells
//
// i_item carries one operation per item: a cost table write, a query append
// or a database symbol. o_result carries one item per final database symbol.
// cost write: the block stays ready. query append: the block is busy while
// the new cell gets its column out of the cost ram (32 reads, one row a cycle).
// database symbol, not final: one item every cycle, all active cells
// update their diagonal sums together from the left neighbour.
// final database symbol: the block is busy while the candidate lane runs
// one cell a cycle towards cell 0: first the database-prefix candidates
// drain, then every cell sum is scanned in order.
// the result sits in an output register; while the receiver stalls the
// block finishes its scan but holds off the next result until taken.
// reset: empty query, zero sums, no candidate; cost table and query symbols
// are undefined until written, there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ungapped_overlap_cost_search_core_assert.svh"

module ungapped_overlap_cost_search_core import uocs_pkg::*; #(
    parameter int MAX_QUERY    = 256,
    parameter int COST_BITS    = 8,
    parameter int MAX_DATABASE = 65536
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    uocs_in_if.sink    i_item,
    uocs_out_if.source o_result
);

    localparam int QL_BITS   = $clog2(MAX_QUERY + 1);
    localparam int DB_BITS   = $clog2(MAX_DATABASE);
    localparam int ROWS      = 1 << SYMBOL_BITS;
    localparam int COPY_BITS = SYMBOL_BITS + 1;

    localparam logic [QL_BITS-1:0]   QL_FULL  = QL_BITS'(MAX_QUERY);
    localparam logic [DB_BITS-1:0]   DB_LAST  = DB_BITS'(MAX_DATABASE - 1);
    localparam logic [COPY_BITS-1:0] COPY_END = COPY_BITS'(ROWS);

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_COPY       = 6'b000010,
        ST_DRAIN      = 6'b000100,
        ST_SCAN_START = 6'b001000,
        ST_SCAN       = 6'b010000,
        ST_RESULT     = 6'b100000
    } t_state;

    t_state                 r_state,       n_state;
    logic [QL_BITS-1:0]     r_qlen,        n_qlen;
    logic [QL_BITS-1:0]     r_inflight,    n_inflight;
    logic [DB_BITS-1:0]     r_db_count,    n_db_count;
    logic                   r_db_valid,    n_db_valid;
    t_sum                   r_best_db,     n_best_db;
    t_index                 r_best_db_idx, n_best_db_idx;
    t_sum                   r_best,        n_best;
    t_index                 r_best_idx,    n_best_idx;
    t_symbol                r_load_sym,    n_load_sym;
    logic [COPY_BITS-1:0]   r_copy_k,      n_copy_k;
    logic                   r_rd_valid,    n_rd_valid;
    t_symbol                r_rd_row,      n_rd_row;
    logic                   r_out_valid,   n_out_valid;
    t_sum                   r_out_cost,    n_out_cost;
    t_index                 r_out_idx,     n_out_idx;
    logic                   r_out_case,    n_out_case;

    t_cell_ctrl                 w_ctrl;
    logic                       w_accept;
    logic                       w_ram_we;
    logic [COST_BITS-1:0]       w_ram_rdata;
    logic [COST_BITS+7:0]       w_cost_ext;
    logic [COST_BITS-1:0]       w_cost_wr;
    logic [COST_BITS-1:0]       w_cell_val;
    logic [DB_BITS+INDEX_BITS-1:0] w_pos_ext;
    t_index                     w_pos;
    t_lane                      w_exit;

    t_sum  w_sum    [MAX_QUERY];
    logic  w_active [MAX_QUERY];
    t_lane w_lane   [MAX_QUERY];

    assign w_accept      = i_item.valid & i_item.ready;
    assign i_item.ready  = (r_state == ST_IDLE);

    // cost kept in its low COST_BITS bits, zero-extended when wider
    assign w_cost_ext = {{COST_BITS{1'b0}}, i_item.cost_value};
    assign w_cost_wr  = w_cost_ext[COST_BITS-1:0];
    assign w_cell_val = r_rd_valid ? w_ram_rdata : w_cost_wr;

    // database position reported in its low 16 bits
    assign w_pos_ext = {{INDEX_BITS{1'b0}}, r_db_count};
    assign w_pos     = w_pos_ext[INDEX_BITS-1:0];

    assign w_ram_we = w_accept && (i_item.operation == OP_COST_WRITE);

    // full cost table, read only to fill the column of a new cell
    uocs_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (COST_ENTRIES)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr ({i_item.cost_row, i_item.cost_column}),
        .i_wdata (w_cost_wr),
        .i_raddr ({r_copy_k[SYMBOL_BITS-1:0], r_load_sym}),
        .o_rdata (w_ram_rdata)
    );

    // the row of cells; sums move right, candidates move left
    for (genvar gi = 0; gi < MAX_QUERY; gi++) begin : g_cell
        t_sum  w_left;
        logic  w_left_act;
        logic  w_right_act;
        t_lane w_in;

        if (gi == 0) begin : g_head
            assign w_left     = '0;
            assign w_left_act = 1'b1;
        end else begin : g_body_left
            assign w_left     = w_sum[gi-1];
            assign w_left_act = w_active[gi-1];
        end

        if (gi == MAX_QUERY - 1) begin : g_tail
            assign w_right_act = 1'b0;
            assign w_in        = '0;
        end else begin : g_body_right
            assign w_right_act = w_active[gi+1];
            assign w_in        = w_lane[gi+1];
        end

        uocs_cell #(
            .COST_BITS (COST_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (w_ctrl),
            .i_cost_val     (w_cell_val),
            .i_left_sum     (w_left),
            .i_left_active  (w_left_act),
            .i_right_active (w_right_act),
            .i_lane         (w_in),
            .i_index        (INDEX_BITS'(gi)),
            .o_sum          (w_sum[gi]),
            .o_active       (w_active[gi]),
            .o_lane         (w_lane[gi])
        );
    end

    // candidates leave the lane at cell 0
    assign w_exit = w_lane[0];

    always_comb begin
        n_state       = r_state;
        n_qlen        = r_qlen;
        n_inflight    = r_inflight;
        n_db_count    = r_db_count;
        n_db_valid    = r_db_valid;
        n_best_db     = r_best_db;
        n_best_db_idx = r_best_db_idx;
        n_best        = r_best;
        n_best_idx    = r_best_idx;
        n_load_sym    = r_load_sym;
        n_copy_k      = r_copy_k;
        n_rd_valid    = 1'b0;
        n_rd_row      = r_rd_row;
        n_out_valid   = r_out_valid & ~o_result.ready;
        n_out_cost    = r_out_cost;
        n_out_idx     = r_out_idx;
        n_out_case    = r_out_case;

        w_ctrl            = '0;
        w_ctrl.db_sym     = i_item.symbol;
        w_ctrl.db_pos     = w_pos;
        w_ctrl.cost_row   = i_item.cost_row;
        w_ctrl.cost_col   = i_item.cost_column;
        w_ctrl.append_sym = i_item.symbol;
        w_ctrl.load_we    = r_rd_valid;
        w_ctrl.load_row   = r_rd_row;

        // a lane exit is a query candidate during the scan, else a database one
        if (w_exit.valid) begin
            n_inflight = n_inflight - QL_BITS'(1);
            if (r_state == ST_SCAN) begin
                if (w_exit.value <= r_best) begin
                    n_best     = w_exit.value;
                    n_best_idx = w_exit.index;
                end
            end else if (!r_db_valid || (w_exit.value <= r_best_db)) begin
                n_best_db     = w_exit.value;
                n_best_db_idx = w_exit.index;
                n_db_valid    = 1'b1;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_item.operation)
                        OP_COST_WRITE: begin
                            w_ctrl.cost_we = 1'b1;
                        end
                        OP_QUERY_APPEND: begin
                            // appends past a full query are dropped
                            if (r_qlen != QL_FULL) begin
                                w_ctrl.append = 1'b1;
                                n_qlen        = r_qlen + QL_BITS'(1);
                                n_load_sym    = i_item.symbol;
                                n_copy_k      = '0;
                                n_state       = ST_COPY;
                            end
                        end
                        OP_DATABASE: begin
                            w_ctrl.db_step = 1'b1;
                            if (r_qlen != '0) begin
                                n_inflight = n_inflight + QL_BITS'(1);
                            end
                            if (r_db_count != DB_LAST) begin
                                n_db_count = r_db_count + DB_BITS'(1);
                            end
                            if (i_item.final_symbol) begin
                                n_state = ST_DRAIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COPY: begin
                // read row k, write row k-1 into the new cell
                if (r_copy_k != COPY_END) begin
                    n_rd_valid = 1'b1;
                    n_rd_row   = r_copy_k[SYMBOL_BITS-1:0];
                    n_copy_k   = r_copy_k + COPY_BITS'(1);
                end else begin
                    w_ctrl.load_done = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (r_inflight == '0) begin
                    n_state = ST_SCAN_START;
                end
            end
            ST_SCAN_START: begin
                w_ctrl.scan_inject = 1'b1;
                n_inflight         = n_inflight + r_qlen;
                n_best             = SUM_MAX;
                n_best_idx         = '0;
                n_state            = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_inflight == '0) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    // database-prefix candidate wins ties over the query scan
                    if (r_db_valid && (r_best_db <= r_best)) begin
                        n_out_cost = r_best_db;
                        n_out_idx  = r_best_db_idx;
                        n_out_case = 1'b1;
                    end else begin
                        n_out_cost = r_best;
                        n_out_idx  = r_best_idx;
                        n_out_case = 1'b0;
                    end
                    // search state back to reset, query and costs stay
                    w_ctrl.clear  = 1'b1;
                    n_db_count    = '0;
                    n_db_valid    = 1'b0;
                    n_best_db     = SUM_MAX;
                    n_best_db_idx = '0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_qlen        <= '0;
            r_inflight    <= '0;
            r_db_count    <= '0;
            r_db_valid    <= 1'b0;
            r_best_db     <= SUM_MAX;
            r_best_db_idx <= '0;
            r_copy_k      <= '0;
            r_rd_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_qlen        <= n_qlen;
            r_inflight    <= n_inflight;
            r_db_count    <= n_db_count;
            r_db_valid    <= n_db_valid;
            r_best_db     <= n_best_db;
            r_best_db_idx <= n_best_db_idx;
            r_copy_k      <= n_copy_k;
            r_rd_valid    <= n_rd_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_load_sym <= n_load_sym;
        r_rd_row   <= n_rd_row;
        r_out_cost <= n_out_cost;
        r_out_idx  <= n_out_idx;
        r_out_case <= n_out_case;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.best_cost  = r_out_cost;
    assign o_result.end_index  = r_out_idx;
    assign o_result.match_case = r_out_case;

    // scan must not start before every database candidate has left the lane
    `UOCS_ASSERT(a_scan_after_drain, (r_state == ST_SCAN_START) |-> (r_inflight == '0), "scan started with candidates in flight")
    // nothing can travel the lane while the query is empty
    `UOCS_ASSERT(a_lane_needs_query, w_exit.valid |-> (r_qlen != '0), "lane exit with empty query")
    `UOCS_ASSERT(a_qlen_bound, (r_qlen <= QL_FULL) && (r_inflight <= QL_FULL), "query length or lane count past bound")
    `UOCS_ASSERT(a_result_loads, ((r_state == ST_RESULT) && (!r_out_valid || o_result.ready)) |=> (r_out_valid && (r_state == ST_IDLE)), "result not loaded")
    `UOCS_ASSERT_ALWAYS(a_reset_idle, (!i_rst_n) |=> ((r_state == ST_IDLE) && !r_out_valid), "reset did not idle the block")

endmodule
`default_nettype wire

### sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top - overlap cost search core testbench
// drives cost table writes, query appends and database runs through the item
// channel, predicts each overlap result in step with accepted items and
// compares every result item against the oldest prediction, field by field
// ---------------------------------------------------------------------------
module tb_top import uocs_pkg::*; ();

    localparam int MAX_QUERY    = 256;
    localparam int MAX_DATABASE = 65536;
    localparam int POS_LIMIT    = MAX_DATABASE - 1;
    localparam int RANDOM_ITEMS = 350;
    // settle wait, sized from the query bound plus margin for a stalled receiver
    localparam int DRAIN_CYCLES = 2 * MAX_QUERY + 64;
    localparam int CYCLE_LIMIT  = 4_000_000;

    // code outside the defined operations, the block ignores it
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // rows of the cost table with a fixed shape after the table load
    localparam t_symbol ZERO_ROW = 5'd0;
    localparam t_symbol TIE_ROW  = 5'd1;
    localparam t_symbol PEAK_ROW = 5'd31;

    typedef logic [$clog2(MAX_QUERY)-1:0] t_qidx;

    typedef struct packed {
        logic [1:0] op;
        t_symbol    sym;
        t_symbol    row;
        t_symbol    col;
        logic [7:0] value;
        logic       fin;
    } t_search_item;

    typedef struct packed {
        t_sum   best_cost;
        t_index end_index;
        logic   match_case;
    } t_overlap_result;

    logic i_clk;
    logic i_rst_n;

    uocs_in_if  item_if ();
    uocs_out_if result_if ();

    ungapped_overlap_cost_search_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // predictor copy of the block state
    logic [7:0]  cost_mem [COST_ENTRIES];
    t_symbol     query_mem [MAX_QUERY];
    t_sum        diag_sums [MAX_QUERY];
    int unsigned query_len;
    t_index      db_pos;
    t_sum        best_db_cost;
    t_index      best_db_pos;
    logic        db_seen;

    t_overlap_result pending_overlaps [$];

    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned calm_items;
    int unsigned stall_cycles = 0;
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // search state back to its post-reset values, table and query kept
    function automatic void clear_search();
        foreach (diag_sums[i]) diag_sums[i] = '0;
        db_pos       = '0;
        best_db_cost = SUM_MAX;
        best_db_pos  = '0;
        db_seen      = 1'b0;
    endfunction

    // advance the predictor by one accepted item, queue any overlap result
    function automatic void predict_overlap(input t_search_item it);
        logic [SUM_BITS:0] total;
        t_sum              carry;
        t_sum              prev;
        t_sum              best;
        t_index            win;
        logic              mcase;
        case (it.op)
            OP_COST_WRITE: begin
                cost_mem[{it.row, it.col}] = it.value;
            end
            OP_QUERY_APPEND: begin
                // appends past a full query are dropped
                if (query_len < MAX_QUERY) begin
                    query_mem[t_qidx'(query_len)] = it.sym;
                    query_len++;
                end
            end
            OP_DATABASE: begin
                // each cell takes its left neighbour's old sum plus the cost
                carry = '0;
                for (int i = 0; i < query_len; i++) begin
                    prev                  = diag_sums[t_qidx'(i)];
                    total                 = carry + cost_mem[{it.sym, query_mem[t_qidx'(i)]}];
                    diag_sums[t_qidx'(i)] = total[SUM_BITS] ? SUM_MAX : total[SUM_BITS-1:0];
                    carry                 = prev;
                end
                // last cell gives a database-prefix candidate, later ties win
                if (query_len > 0) begin
                    if (!db_seen || diag_sums[t_qidx'(query_len-1)] <= best_db_cost) begin
                        best_db_cost = diag_sums[t_qidx'(query_len-1)];
                        best_db_pos  = db_pos;
                        db_seen      = 1'b1;
                    end
                end
                if (db_pos < POS_LIMIT) db_pos++;
                if (it.fin) begin
                    // query-prefix candidates first, database ones after
                    best  = SUM_MAX;
                    win   = '0;
                    mcase = 1'b0;
                    if (query_len > 0) begin
                        best = diag_sums[0];
                        for (int i = 1; i < query_len; i++) begin
                            if (diag_sums[t_qidx'(i)] <= best) begin
                                best = diag_sums[t_qidx'(i)];
                                win  = t_index'(i);
                            end
                        end
                    end
                    if (db_seen && best_db_cost <= best) begin
                        best  = best_db_cost;
                        win   = best_db_pos;
                        mcase = 1'b1;
                    end
                    pending_overlaps.push_back('{best, win, mcase});
                    clear_search();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_search_item random_item();
        t_search_item it;
        it.op    = 2'($urandom_range(0, 3));
        it.sym   = t_symbol'($urandom_range(0, 31));
        it.row   = t_symbol'($urandom_range(0, 31));
        it.col   = t_symbol'($urandom_range(0, 31));
        it.value = 8'($urandom_range(0, 255));
        it.fin   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // offer one item, hold it until taken, then advance the predictor
    task automatic send_item(input t_search_item it);
        int unsigned gap;
        if (calm_items > 0) begin
            calm_items--;
        end else if (!no_idle && $urandom_range(0, 39) == 0) begin
            calm_items = $urandom_range(30, 120);
        end
        if (!no_idle && calm_items == 0 && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.operation    <= it.op;
        item_if.symbol       <= it.sym;
        item_if.cost_row     <= it.row;
        item_if.cost_column  <= it.col;
        item_if.cost_value   <= it.value;
        item_if.final_symbol <= it.fin;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        predict_overlap(it);
    endtask

    task automatic send_database(input t_symbol sym, input logic fin);
        t_search_item it;
        it     = random_item();
        it.op  = OP_DATABASE;
        it.sym = sym;
        it.fin = fin;
        send_item(it);
    endtask

    task automatic send_append(input t_symbol sym);
        t_search_item it;
        it     = random_item();
        it.op  = OP_QUERY_APPEND;
        it.sym = sym;
        send_item(it);
    endtask

    task automatic send_cost_write(input t_symbol row, input t_symbol col,
                                   input logic [7:0] value);
        t_search_item it;
        it       = random_item();
        it.op    = OP_COST_WRITE;
        it.row   = row;
        it.col   = col;
        it.value = value;
        send_item(it);
    endtask

    task automatic send_noise();
        t_search_item it;
        it    = random_item();
        it.op = OP_UNKNOWN;
        send_item(it);
    endtask

    // database symbols with no query: counted, no candidate, default result
    task automatic test_empty_query();
        send_database(t_symbol'($urandom_range(0, 31)), 1'b1);
        send_noise();
        send_database(5'd31, 1'b0);
        send_database(5'd0, 1'b0);
        send_noise();
        send_database(t_symbol'($urandom_range(0, 31)), 1'b1);
    endtask

    // every entry written once, so no later read touches an unwritten one
    task automatic test_cost_table_load();
        logic [7:0] value;
        for (int r = 0; r < 32; r++) begin
            for (int c = 0; c < 32; c++) begin
                case (t_symbol'(r))
                    ZERO_ROW: value = 8'h00;
                    TIE_ROW:  value = 8'($urandom_range(0, 1));
                    PEAK_ROW: value = 8'hFF;
                    default:  value = 8'($urandom_range(0, 255));
                endcase
                send_cost_write(t_symbol'(r), t_symbol'(c), value);
            end
        end
    endtask

    task automatic test_directed();
        t_search_item it;
        // extreme query symbols, then a final on the first database symbol
        send_append(5'd0);
        send_append(5'd31);
        send_database(PEAK_ROW, 1'b1);
        // zero costs: every candidate ties, the latest one wins
        send_database(ZERO_ROW, 1'b0);
        send_database(ZERO_ROW, 1'b1);
        // query grown in the middle of a search, the new cell starts at zero
        send_database(PEAK_ROW, 1'b0);
        send_append(5'd17);
        send_database(TIE_ROW, 1'b0);
        send_database(ZERO_ROW, 1'b1);
        // final flag on the other operations has no effect
        it       = random_item();
        it.op    = OP_COST_WRITE;
        it.row   = PEAK_ROW;
        it.col   = 5'd31;
        it.value = 8'hFF;
        it.fin   = 1'b1;
        send_item(it);
        it     = random_item();
        it.op  = OP_QUERY_APPEND;
        it.sym = 5'd31;
        it.fin = 1'b1;
        send_item(it);
        it     = random_item();
        it.op  = OP_UNKNOWN;
        it.fin = 1'b1;
        send_item(it);
        // maximum costs along every diagonal
        send_database(PEAK_ROW, 1'b0);
        send_database(PEAK_ROW, 1'b0);
        send_database(TIE_ROW, 1'b0);
        send_database(t_symbol'($urandom_range(0, 31)), 1'b1);
    endtask

    // well-formed searches with random content, sprinkled with table
    // rewrites, mid-search appends and ignored codes
    task automatic test_random_searches();
        int unsigned sent;
        int unsigned run_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_append(t_symbol'($urandom_range(0, 31)));
                    sent++;
                end
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            for (int n = 0; n < run_len; n++) begin
                case ($urandom_range(0, 39))
                    0, 1: begin
                        send_cost_write(t_symbol'($urandom_range(0, 31)),
                                        t_symbol'($urandom_range(0, 31)),
                                        8'($urandom_range(0, 255)));
                        sent++;
                    end
                    2: begin
                        send_append(t_symbol'($urandom_range(0, 31)));
                        sent++;
                    end
                    3: send_noise();
                    default: ;
                endcase
                send_database(t_symbol'($urandom_range(0, 31)), n == run_len - 1);
                sent++;
            end
        end
    endtask

    // fill the query and push past it, then searches with no idling
    task automatic test_query_full();
        int unsigned extra;
        int unsigned run_len;
        extra = MAX_QUERY - query_len + 6;
        repeat (extra) send_append(t_symbol'($urandom_range(0, 31)));
        no_idle = 1'b1;
        repeat (6) begin
            run_len = $urandom_range(1, 20);
            for (int n = 0; n < run_len; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_cost_write(t_symbol'($urandom_range(0, 31)),
                                    t_symbol'($urandom_range(0, 31)),
                                    8'($urandom_range(0, 255)));
                end
                send_database(t_symbol'($urandom_range(0, 31)), n == run_len - 1);
            end
        end
    endtask

    // result side: compare against the oldest prediction, random stalls
    always @(posedge i_clk) begin : result_check
        t_overlap_result want;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (pending_overlaps.size() == 0) begin
                $error("result item with no prediction waiting");
                error_count++;
            end else begin
                want = pending_overlaps.pop_front();
                if (result_if.best_cost !== want.best_cost) begin
                    $error("best_cost: expected %0d, got %0d",
                           want.best_cost, result_if.best_cost);
                    error_count++;
                end
                if (result_if.end_index !== want.end_index) begin
                    $error("end_index: expected %0d, got %0d",
                           want.end_index, result_if.end_index);
                    error_count++;
                end
                if (result_if.match_case !== want.match_case) begin
                    $error("match_case: expected %0d, got %0d",
                           want.match_case, result_if.match_case);
                    error_count++;
                end
            end
        end
        if (stall_cycles != 0) begin
            stall_cycles--;
            result_if.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            stall_cycles = $urandom_range(1, 12) - 1;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // watchdog on the total run length
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        calm_items   = 0;
        no_idle      = 1'b0;
        query_len    = 0;
        clear_search();
        i_rst_n              <= 1'b0;
        item_if.valid        <= 1'b0;
        item_if.operation    <= OP_COST_WRITE;
        item_if.symbol       <= '0;
        item_if.cost_row     <= '0;
        item_if.cost_column  <= '0;
        item_if.cost_value   <= '0;
        item_if.final_symbol <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_query();
        test_cost_table_load();
        test_directed();
        test_random_searches();
        test_query_full();

        // all stimulus taken, wait for outstanding results then settle
        item_if.valid <= 1'b0;
        while (pending_overlaps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_overlaps.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/uocs_pkg.sv
rtl/uocs_in_if.sv
rtl/uocs_out_if.sv
rtl/uocs_ram.sv
rtl/uocs_cell.sv
rtl/ungapped_overlap_cost_search_core.sv
sim/tb_top.sv
